### design/rdlm_pkg.sv
// ---------------------------------------------------------------------------
// rdlm_pkg
// Types and constants shared by the reject delay line merger.
// ---------------------------------------------------------------------------
`default_nettype none

package rdlm_pkg;

   localparam int MASK_W   = 4;
   localparam int COUNT_W  = 3;
   localparam int KIND_W   = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 4;
   localparam int MAX_TAP  = 16;

   typedef logic [MASK_W-1:0] mask_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_SHORT   = 2'd0,
      KIND_LONG    = 2'd1,
      KIND_PUSH    = 2'd2,
      KIND_CONTROL = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INTERVAL = 1'b0,
      CSR_ENABLE   = 1'b1
   } csr_index_type;

   // shift request into the delay line
   typedef struct packed {
      logic     shift;
      mask_type fill;
   } line_ctrl_type;

   // tap and the two entries below it, before any shift
   typedef struct packed {
      mask_type tap;
      mask_type prev1;
      mask_type prev2;
   } line_tap_type;

endpackage

`default_nettype wire

### design/rdlm_ifs.sv
// ---------------------------------------------------------------------------
// rdlm request / response channels
// Valid/ready channels carrying one request word and one response word.
// ---------------------------------------------------------------------------
`default_nettype none

interface rdlm_req_if;
   logic                        valid;
   logic                        ready;
   logic [rdlm_pkg::KIND_W-1:0] kind;
   logic                        station;
   rdlm_pkg::mask_type          temp_result;

   modport source (output valid, output kind, output station, output temp_result,
                   input ready);
   modport sink   (input valid, input kind, input station, input temp_result,
                   output ready);
endinterface

interface rdlm_rsp_if;
   logic                         valid;
   logic                         ready;
   rdlm_pkg::mask_type           reject_mask;
   logic [rdlm_pkg::COUNT_W-1:0] bad_count;
   logic                         sent;

   modport source (output valid, output reject_mask, output bad_count, output sent,
                   input ready);
   modport sink   (input valid, input reject_mask, input bad_count, input sent,
                   output ready);
endinterface

`default_nettype wire

### design/rdlm_delay_line.sv
// ---------------------------------------------------------------------------
// rdlm_delay_line
// Variable-length shift line of reject masks with a tap window read.
// ---------------------------------------------------------------------------
`default_nettype none

module rdlm_delay_line #(
   parameter int LINE_LEN = 16,
   localparam int POS_W   = $clog2(LINE_LEN)
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire [POS_W-1:0]              pos,
   input  rdlm_pkg::line_ctrl_type      ctrl,
   output rdlm_pkg::line_tap_type       taps
);
   import rdlm_pkg::*;

   mask_type     line_ff  [LINE_LEN];
   mask_type     line_in  [LINE_LEN];
   line_tap_type window   [LINE_LEN];

   for (genvar g = 0; g < LINE_LEN; g++) begin : g_entry
      if (g == 0) begin : g_head
         assign line_in[g] = ctrl.shift ? ctrl.fill : line_ff[g];
         assign window[g]  = '{tap: line_ff[g], prev1: '0, prev2: '0};
      end else if (g == 1) begin : g_second
         localparam logic [POS_W-1:0] IDX = POS_W'(g);
         assign line_in[g] = (ctrl.shift && IDX <= pos) ? line_ff[g-1] : line_ff[g];
         assign window[g]  = '{tap: line_ff[g], prev1: line_ff[g-1], prev2: '0};
      end else begin : g_rest
         localparam logic [POS_W-1:0] IDX = POS_W'(g);
         assign line_in[g] = (ctrl.shift && IDX <= pos) ? line_ff[g-1] : line_ff[g];
         assign window[g]  = '{tap: line_ff[g], prev1: line_ff[g-1], prev2: line_ff[g-2]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            line_ff[g] <= '0;
         end else begin
            line_ff[g] <= line_in[g];
         end
      end
   end

   assign taps = window[pos];

endmodule

`default_nettype wire

### design/reject_delay_line_merger.sv
// ---------------------------------------------------------------------------
// reject_delay_line_merger
// Merges station defect masks through a reject delay line into valve words.
// ---------------------------------------------------------------------------
// Usage:
//   req_ch  : request words (kind, station, temp_result), valid/ready.
//   rsp_ch  : one response word (reject_mask, bad_count, sent) per control
//             request; merge and push requests give no response.
//   csr_*   : write-only port; index 0 interval (tap position), 1 enable.
//             Write only while the block is idle.
// Timing:
//   A request is registered on acceptance in the input register and is
//   processed there; a control response then goes to the response register.
//   One request per clock is sustained unless a control request waits on a
//   stalled response; updates of one request are seen by the next directly.
// Stall:
//   The response register holds while rsp_ch.ready is low; further merge
//   and push requests still flow, a control request waits in the input
//   register and req_ch.ready drops behind it.
// Reset:
//   Synchronous; delay line, pending and previous masks cleared,
//   interval 0, enable 1, both channels empty.
// ---------------------------------------------------------------------------
`default_nettype none

module reject_delay_line_merger #(
   parameter int DELAY_DEPTH = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   rdlm_req_if.sink                           req_ch,
   rdlm_rsp_if.source                         rsp_ch,
   input  wire                                csr_we,
   input  wire [rdlm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [rdlm_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import rdlm_pkg::*;

   localparam int LINE_LEN = (DELAY_DEPTH < MAX_TAP) ? DELAY_DEPTH : MAX_TAP;
   localparam int POS_W    = $clog2(LINE_LEN);
   localparam logic [CSR_DATA_W-1:0] LAST_POS = CSR_DATA_W'(LINE_LEN - 1);

   // configuration
   logic [CSR_DATA_W-1:0] interval_ff;
   logic                  enable_ff;

   // input register
   logic     s1_valid_ff;
   kind_type s1_kind_ff;
   logic     s1_station_ff;
   mask_type s1_temp_ff;

   // block state
   mask_type pending_ff [2];
   mask_type pending_in [2];
   mask_type prev_ff    [2];
   mask_type prev_in    [2];
   logic     last_ff;
   logic     last_in;

   // response register
   logic               rsp_valid_ff;
   mask_type           rsp_mask_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_sent_ff;

   logic               s1_go;
   logic               load_rsp;
   logic [POS_W-1:0]   pos;
   line_ctrl_type      line_ctrl;
   line_tap_type       taps;
   logic               do_shift;
   mask_type           neigh_src;
   mask_type           merged;
   logic [COUNT_W-1:0] merged_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= '0;
         enable_ff   <= 1'b1;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_INTERVAL: begin
               interval_ff <= csr_wdata;
            end
            CSR_ENABLE: begin
               enable_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   assign pos = POS_W'((interval_ff > LAST_POS) ? LAST_POS : interval_ff);

   assign s1_go = s1_valid_ff &&
                  (s1_kind_ff != KIND_CONTROL || !rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         s1_kind_ff    <= kind_type'(req_ch.kind);
         s1_station_ff <= req_ch.station;
         s1_temp_ff    <= req_ch.temp_result;
      end
   end

   rdlm_delay_line #(
      .LINE_LEN (LINE_LEN)
   ) u_line (
      .clock (clock),
      .reset (reset),
      .pos   (pos),
      .ctrl  (line_ctrl),
      .taps  (taps)
   );

   // control merge; neighbour read after the line has shifted
   assign do_shift     = (s1_station_ff == last_ff);
   assign neigh_src    = do_shift ? taps.prev2 : taps.prev1;
   assign merged       = pending_ff[s1_station_ff] | {taps.tap[MASK_W-2:0], 1'b0}
                         | {{(MASK_W-1){1'b0}}, neigh_src[MASK_W-1]};
   assign merged_count = COUNT_W'(merged[0]) + COUNT_W'(merged[1])
                         + COUNT_W'(merged[2]) + COUNT_W'(merged[3]);

   always_comb begin
      pending_in = pending_ff;
      prev_in    = prev_ff;
      last_in    = last_ff;
      line_ctrl  = '{shift: 1'b0, fill: '0};
      load_rsp   = 1'b0;
      if (s1_go) begin
         case (s1_kind_ff)
            KIND_SHORT: begin
               pending_in[s1_station_ff] = {prev_ff[s1_station_ff][MASK_W-2:0], 1'b0}
                                           | s1_temp_ff;
            end
            KIND_LONG: begin
               pending_in[s1_station_ff] = pending_ff[s1_station_ff]
                                           | {{(MASK_W-1){1'b0}}, s1_temp_ff[MASK_W-1]};
               prev_in[s1_station_ff]    = s1_temp_ff;
            end
            KIND_PUSH: begin
               if (s1_station_ff) begin
                  line_ctrl     = '{shift: 1'b1, fill: pending_ff[1]};
                  pending_in[1] = '0;
                  last_in       = 1'b1;
               end
            end
            KIND_CONTROL: begin
               line_ctrl = '{shift: do_shift, fill: '0};
               last_in   = 1'b0;
               load_rsp  = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff[0] <= '0;
         pending_ff[1] <= '0;
         prev_ff[0]    <= '0;
         prev_ff[1]    <= '0;
         last_ff       <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         prev_ff    <= prev_in;
         last_ff    <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_mask_ff  <= enable_ff ? merged : '0;
         rsp_count_ff <= merged_count;
         rsp_sent_ff  <= enable_ff;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.reject_mask = rsp_mask_ff;
   assign rsp_ch.bad_count   = rsp_count_ff;
   assign rsp_ch.sent        = rsp_sent_ff;

   // a waiting request keeps its slot and its contents
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_go |=> s1_valid_ff && $stable(s1_kind_ff)
                                && $stable(s1_station_ff) && $stable(s1_temp_ff))
      else $error("input register lost a stalled word");

   // a control request never overwrites an untaken response
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> !rsp_valid_ff || rsp_ch.ready)
      else $error("response overwritten while stalled");

   // suppressed responses carry an empty mask
   a_suppressed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_sent_ff |-> rsp_mask_ff == '0)
      else $error("mask leaked while disabled");

   // a push from the second station empties its pending mask
   a_push_clears: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_kind_ff == KIND_PUSH && s1_station_ff |=> pending_ff[1] == '0 && last_ff)
      else $error("push did not clear pending mask");

   // a control request resets the last-pushed marker
   a_control_marker: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> !last_ff && rsp_valid_ff)
      else $error("control request left marker set");

endmodule

`default_nettype wire

### bench/reject_delay_line_merger_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// reject_delay_line_merger_test
// Self-checking bench for the reject delay line merger. A queue of request
// words feeds a clocked driver and a clocked monitor compares every response
// word with an in-bench model of the delay line, pending and previous masks.
// Runs a directed opening, then random product sequences under several
// interval/enable settings, with random gaps and one long response stall.
// ---------------------------------------------------------------------------

module reject_delay_line_merger_test;

   import rdlm_pkg::*;

   localparam int LINE_DEPTH  = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_AFTER  = 160;
   localparam int HOLD_CYCLES = 300;
   localparam int N_PHASES    = 8;

   typedef struct packed {
      kind_type kind;
      logic     station;
      mask_type temp_result;
   } req_word_type;

   typedef struct packed {
      mask_type           reject_mask;
      logic [COUNT_W-1:0] bad_count;
      logic               sent;
   } rsp_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   rdlm_req_if req_ch ();
   rdlm_rsp_if rsp_ch ();

   reject_delay_line_merger DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // model state
   mask_type    line_q [LINE_DEPTH];
   mask_type    pend_q [2];
   mask_type    prev_q [2];
   logic        last_pushed;
   logic [3:0]  cfg_interval;
   logic        cfg_enable;

   req_word_type req_backlog [$];
   rsp_word_type reject_due [$];

   req_word_type next_word;
   logic         offer_taken = 1'b0;
   logic         smooth = 1'b0;
   logic         hold_done = 1'b0;
   int unsigned  gap_left = 0;
   int unsigned  stall_left = 0;
   int unsigned  hold_left = 0;
   int unsigned  words_taken = 0;
   int unsigned  mismatches = 0;
   int unsigned  cycles = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int unsigned idle_gap();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 70) return 0;
      else if (r < 92) return $urandom_range(3, 1);
      else return $urandom_range(40, 10);
   endfunction

   task automatic predict_reject(input req_word_type w);
      int unsigned  pos;
      mask_type     tap;
      mask_type     pend;
      mask_type     merged;
      rsp_word_type r;
      pos = (cfg_interval > LINE_DEPTH - 1) ? LINE_DEPTH - 1 : cfg_interval;
      case (w.kind)
         KIND_SHORT: begin
            pend_q[w.station] = {prev_q[w.station][2:0], 1'b0} | w.temp_result;
         end
         KIND_LONG: begin
            pend_q[w.station] = pend_q[w.station] | {3'b000, w.temp_result[3]};
            prev_q[w.station] = w.temp_result;
         end
         KIND_PUSH: begin
            if (w.station) begin
               for (int i = pos; i > 0; i--) line_q[i] = line_q[i-1];
               line_q[0] = pend_q[1];
               pend_q[1] = '0;
               last_pushed = 1'b1;
            end
         end
         default: begin
            tap  = line_q[pos];
            pend = pend_q[w.station];
            if (w.station == last_pushed) begin
               for (int i = pos; i > 0; i--) line_q[i] = line_q[i-1];
               line_q[0] = '0;
            end
            merged = pend | {tap[2:0], 1'b0};
            // neighbour tap reads as zero at interval zero
            if (pos != 0) merged = merged | {3'b000, line_q[pos-1][3]};
            r.reject_mask = cfg_enable ? merged : '0;
            r.bad_count   = COUNT_W'($countones(merged));
            r.sent        = cfg_enable;
            reject_due.push_back(r);
            last_pushed = 1'b0;
         end
      endcase
   endtask

   task automatic add_word(input kind_type k, input logic st, input mask_type t);
      req_word_type w;
      w.kind        = k;
      w.station     = st;
      w.temp_result = t;
      req_backlog.push_back(w);
   endtask

   task automatic fill_phase(input int unsigned n);
      int unsigned count;
      logic        first;
      logic        st;
      kind_type    k;
      count = 0;
      while (count < n) begin
         if ($urandom_range(9) < 2) begin
            st = 1'($urandom_range(1));
            k  = kind_type'($urandom_range(3));
            add_word(k, st, mask_type'($urandom_range(15)));
            if (!(k == KIND_PUSH && !st)) count++;
         end else begin
            first = 1'($urandom_range(1));
            for (int s = 0; s < 2; s++) begin
               st = first ^ s[0];
               if ($urandom_range(3) != 0) begin
                  add_word(KIND_SHORT, st, mask_type'($urandom_range(15)));
                  count++;
               end
               if ($urandom_range(3) != 0) begin
                  add_word(KIND_LONG, st, mask_type'($urandom_range(15)));
                  count++;
               end
            end
            if ($urandom_range(9) != 0) begin
               add_word(KIND_PUSH, 1'b1, mask_type'($urandom_range(15)));
               count++;
            end
            repeat ($urandom_range(2, 1)) begin
               add_word(KIND_CONTROL, 1'($urandom_range(1)), mask_type'($urandom_range(15)));
               count++;
            end
         end
      end
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_INTERVAL) cfg_interval = data;
      else cfg_enable = data[0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      while (req_backlog.size() != 0 || req_ch.valid || reject_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || offer_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (req_backlog.size() > 0) begin
            next_word = req_backlog.pop_front();
            req_ch.kind        <= next_word.kind;
            req_ch.station     <= next_word.station;
            req_ch.temp_result <= next_word.temp_result;
            req_ch.valid       <= 1'b1;
            gap_left = smooth ? 0 : idle_gap();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         offer_taken <= 1'b0;
      end else begin
         offer_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            predict_reject({kind_type'(req_ch.kind), req_ch.station, req_ch.temp_result});
            words_taken++;
         end
      end
   end

   // response side back-pressure, with one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (!hold_done && words_taken >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!smooth && $urandom_range(3) == 0) stall_left = idle_gap();
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_word_type want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (reject_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: mask %h count %0d sent %b",
                        rsp_ch.reject_mask, rsp_ch.bad_count, rsp_ch.sent);
         end else begin
            want = reject_due.pop_front();
            if (rsp_ch.reject_mask !== want.reject_mask ||
                rsp_ch.bad_count !== want.bad_count || rsp_ch.sent !== want.sent) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp mask %h count %0d sent %b, got mask %h count %0d sent %b",
                           want.reject_mask, want.bad_count, want.sent,
                           rsp_ch.reject_mask, rsp_ch.bad_count, rsp_ch.sent);
            end
         end
      end
   end

   initial begin
      logic [3:0] iv;
      logic       en;
      req_ch.valid       = 1'b0;
      req_ch.kind        = KIND_SHORT;
      req_ch.station     = 1'b0;
      req_ch.temp_result = '0;
      rsp_ch.ready       = 1'b0;
      for (int i = 0; i < LINE_DEPTH; i++) line_q[i] = '0;
      pend_q       = '{default: '0};
      prev_q       = '{default: '0};
      last_pushed  = 1'b0;
      cfg_interval = '0;
      cfg_enable   = 1'b1;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed opening at reset settings: interval zero, enabled
      add_word(KIND_SHORT, 1'b0, 4'hf);
      add_word(KIND_LONG, 1'b0, 4'hf);
      add_word(KIND_CONTROL, 1'b0, 4'h0);
      add_word(KIND_SHORT, 1'b1, 4'h0);
      add_word(KIND_LONG, 1'b1, 4'h8);
      add_word(KIND_SHORT, 1'b1, 4'h5);
      add_word(KIND_PUSH, 1'b1, 4'h0);
      add_word(KIND_PUSH, 1'b0, 4'hf);
      add_word(KIND_CONTROL, 1'b1, 4'hf);
      add_word(KIND_CONTROL, 1'b1, 4'h0);
      add_word(KIND_LONG, 1'b1, 4'h7);
      add_word(KIND_SHORT, 1'b1, 4'ha);
      add_word(KIND_PUSH, 1'b1, 4'h3);
      add_word(KIND_CONTROL, 1'b0, 4'h0);
      fill_phase(80);
      drain();

      for (int p = 0; p < N_PHASES; p++) begin
         case (p)
            0: begin iv = 4'd15; en = 1'b1; end
            1: begin iv = 4'd0;  en = 1'b0; end
            2: begin iv = 4'd1;  en = 1'b1; end
            3: begin iv = 4'd15; en = 1'b0; end
            default: begin iv = 4'($urandom_range(15)); en = 1'($urandom_range(1)); end
         endcase
         write_csr(CSR_INTERVAL, iv);
         write_csr(CSR_ENABLE, {3'($urandom_range(7)), en});
         smooth = (p == 2 || p == 5);
         if (p == 0) begin
            // push a full mask into the head of the line, then shift it with two control requests
            add_word(KIND_SHORT, 1'b1, 4'hf);
            add_word(KIND_PUSH, 1'b1, 4'h0);
            add_word(KIND_CONTROL, 1'b1, 4'h0);
            add_word(KIND_CONTROL, 1'b0, 4'h0);
         end
         fill_phase(95);
         drain();
      end

      if (mismatches == 0 && reject_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
